/* rtl/core/wmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_pkg
// Shared constants and types for the windowed mode filter.
// ----------------------------------------------------------------------------
package wmf_pkg;

    localparam int WINDOW_SIZE = 16;
    localparam int SAMPLE_W    = 16;
    localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int FILL_W      = $clog2(WINDOW_SIZE + 1);

    localparam logic [SAMPLE_W-1:0] CUTOFF_RESET = SAMPLE_W'(10000);

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [FILL_W-1:0]   t_fill;

    typedef enum logic {
        TS_IDLE,
        TS_MODE
    } t_top_state;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_FETCH,
        MS_COUNT,
        MS_UPDATE,
        MS_DONE
    } t_mode_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mode_stat;

endpackage

/* rtl/core/windowed_mode_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_mode_filter
// Collects good readings into a window and emits the mode of the window
// (above cutoff, lowest on ties, zero if none) on the beat after it fills.
// ----------------------------------------------------------------------------
// a beat that finds the window not full is taken, and stored if good
// a beat that finds it full is held and starts the mode search, whose length is
//   set by the single match comparator scanning the window
// the result sits in an output register; input stalls while the search runs
// reset: synchronous active low, clears fill count, control and sets cutoff
module windowed_mode_filter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [15:0]           i_sample,
    input  logic                  i_sample_ok,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_mode_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cfg_data
);

    localparam wmf_pkg::t_fill FULL_CNT = wmf_pkg::FILL_W'(wmf_pkg::WINDOW_SIZE);

    wmf_pkg::t_top_state r_state, n_state;
    wmf_pkg::t_fill      r_fill, n_fill;
    wmf_pkg::t_sample    r_cutoff;
    wmf_pkg::t_sample    r_held_sample;
    logic                r_held_ok;
    logic                r_out_valid, n_out_valid;
    wmf_pkg::t_sample    r_out_value;

    logic                w_in_acc;
    logic                w_out_acc;
    logic                w_full;
    logic                w_start;
    logic                w_wr_en;
    wmf_pkg::t_idx       w_wr_addr;
    wmf_pkg::t_sample    w_wr_data;
    wmf_pkg::t_idx       w_rd_addr_a;
    wmf_pkg::t_idx       w_rd_addr_b;
    wmf_pkg::t_sample    w_rd_data_a;
    wmf_pkg::t_sample    w_rd_data_b;
    wmf_pkg::t_mode_stat w_stat;
    wmf_pkg::t_sample    w_mode_value;

    assign w_full     = (r_fill == FULL_CNT);
    // a full window needs the output slot free before it can take the beat
    assign o_in_stall = !((r_state == wmf_pkg::TS_IDLE) && !(w_full && r_out_valid));
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_start    = w_in_acc && w_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wmf_pkg::TS_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_cutoff    <= wmf_pkg::CUTOFF_RESET;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cutoff <= i_cfg_data;
            end
        end
        if (w_start) begin
            r_held_sample <= i_sample;
            r_held_ok     <= i_sample_ok;
        end
        if (w_stat.done) begin
            r_out_value <= w_mode_value;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_fill[wmf_pkg::IDX_W-1:0];
        w_wr_data   = i_sample;
        if (w_out_acc) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            wmf_pkg::TS_IDLE: begin
                if (w_start) begin
                    n_state = wmf_pkg::TS_MODE;
                end else if (w_in_acc && i_sample_ok) begin
                    w_wr_en = 1'b1;
                    n_fill  = r_fill + 1'b1;
                end
            end
            wmf_pkg::TS_MODE: begin
                if (w_stat.done) begin
                    n_out_valid = 1'b1;
                    n_state     = wmf_pkg::TS_IDLE;
                    // window restarts, a good held beat lands in the first slot
                    w_wr_addr   = '0;
                    w_wr_data   = r_held_sample;
                    w_wr_en     = r_held_ok;
                    n_fill      = r_held_ok ? wmf_pkg::FILL_W'(1) : '0;
                end
            end
            default: begin
                n_state = wmf_pkg::TS_IDLE;
            end
        endcase
    end

    wmf_sample_ram u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_addr_a (w_rd_addr_a),
        .i_rd_addr_b (w_rd_addr_b),
        .o_rd_data_a (w_rd_data_a),
        .o_rd_data_b (w_rd_data_b)
    );

    wmf_mode_unit u_mode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_start),
        .i_cutoff     (r_cutoff),
        .i_rd_data_a  (w_rd_data_a),
        .i_rd_data_b  (w_rd_data_b),
        .o_rd_addr_a  (w_rd_addr_a),
        .o_rd_addr_b  (w_rd_addr_b),
        .o_stat       (w_stat),
        .o_mode_value (w_mode_value)
    );

    assign o_out_valid  = r_out_valid;
    assign o_mode_value = r_out_value;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("fill count beyond window size");

    a_full_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == wmf_pkg::TS_MODE) && w_stat.busy)
        else $error("full window beat did not start the mode search");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wmf_pkg::TS_MODE) && w_stat.done |=> o_out_valid && (r_fill <= 1))
        else $error("mode result not presented or window not restarted");

    a_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wmf_pkg::TS_IDLE) |-> !w_stat.busy || w_start)
        else $error("mode unit busy while top is idle");
`endif

endmodule

/* rtl/core/wmf_sample_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_sample_ram
// Window sample store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module wmf_sample_ram (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  wmf_pkg::t_idx    i_wr_addr,
    input  wmf_pkg::t_sample i_wr_data,
    input  wmf_pkg::t_idx    i_rd_addr_a,
    input  wmf_pkg::t_idx    i_rd_addr_b,
    output wmf_pkg::t_sample o_rd_data_a,
    output wmf_pkg::t_sample o_rd_data_b
);

    wmf_pkg::t_sample r_mem [wmf_pkg::WINDOW_SIZE];
    wmf_pkg::t_sample r_rd_a;
    wmf_pkg::t_sample r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* rtl/core/wmf_mode_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmf_mode_unit
// Sequenced mode search: for each entry, counts matches over the window
// with one shared comparator and keeps the best candidate.
// ----------------------------------------------------------------------------
module wmf_mode_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  wmf_pkg::t_sample    i_cutoff,
    input  wmf_pkg::t_sample    i_rd_data_a,
    input  wmf_pkg::t_sample    i_rd_data_b,
    output wmf_pkg::t_idx       o_rd_addr_a,
    output wmf_pkg::t_idx       o_rd_addr_b,
    output wmf_pkg::t_mode_stat o_stat,
    output wmf_pkg::t_sample    o_mode_value
);

    localparam wmf_pkg::t_idx  LAST_IDX = wmf_pkg::IDX_W'(wmf_pkg::WINDOW_SIZE - 1);
    localparam wmf_pkg::t_fill FULL_CNT = wmf_pkg::FILL_W'(wmf_pkg::WINDOW_SIZE);

    wmf_pkg::t_mode_state r_state, n_state;
    wmf_pkg::t_idx        r_i, n_i;
    wmf_pkg::t_fill       r_j, n_j;
    wmf_pkg::t_fill       r_cnt, n_cnt;
    wmf_pkg::t_fill       r_best_cnt, n_best_cnt;
    wmf_pkg::t_sample     r_best_val, n_best_val;

    logic w_match;
    logic w_better;

    // the one shared equality compare used by the inner scan
    assign w_match  = (i_rd_data_b == i_rd_data_a);
    assign w_better = (i_rd_data_a > i_cutoff) &&
                      ((r_cnt > r_best_cnt) ||
                       ((r_cnt == r_best_cnt) && (i_rd_data_a < r_best_val)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wmf_pkg::MS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_cnt      <= n_cnt;
        r_best_cnt <= n_best_cnt;
        r_best_val <= n_best_val;
    end

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_cnt      = r_cnt;
        n_best_cnt = r_best_cnt;
        n_best_val = r_best_val;
        unique case (r_state)
            wmf_pkg::MS_IDLE: begin
                if (i_start) begin
                    n_i        = '0;
                    n_best_cnt = '0;
                    n_best_val = '0;
                    n_state    = wmf_pkg::MS_FETCH;
                end
            end
            wmf_pkg::MS_FETCH: begin
                n_j     = '0;
                n_cnt   = '0;
                n_state = wmf_pkg::MS_COUNT;
            end
            wmf_pkg::MS_COUNT: begin
                // read data is registered, so it belongs to the previous address
                if (r_j != '0 && w_match) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_j == FULL_CNT) begin
                    n_state = wmf_pkg::MS_UPDATE;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            wmf_pkg::MS_UPDATE: begin
                if (w_better) begin
                    n_best_cnt = r_cnt;
                    n_best_val = i_rd_data_a;
                end
                if (r_i == LAST_IDX) begin
                    n_state = wmf_pkg::MS_DONE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = wmf_pkg::MS_FETCH;
                end
            end
            wmf_pkg::MS_DONE: begin
                n_state = wmf_pkg::MS_IDLE;
            end
            default: begin
                n_state = wmf_pkg::MS_IDLE;
            end
        endcase
    end

    assign o_rd_addr_a  = r_i;
    assign o_rd_addr_b  = r_j[wmf_pkg::IDX_W-1:0];
    assign o_stat.busy  = (r_state != wmf_pkg::MS_IDLE);
    assign o_stat.done  = (r_state == wmf_pkg::MS_DONE);
    assign o_mode_value = r_best_val;

endmodule

/* tb/sv/windowed_mode_filter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_mode_filter_tb
// Self-checking bench for the windowed mode filter. A driver feeds readings
// from a queue, an in-bench predictor tracks the window and cutoff and forms
// the expected mode for every beat that finds the window full, and a monitor
// compares each output beat with the oldest expected mode. The cutoff is
// rewritten between phases, including both extremes.
// ----------------------------------------------------------------------------
module windowed_mode_filter_tb;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int SEARCH_CYCLES = wmf_pkg::WINDOW_SIZE * (wmf_pkg::WINDOW_SIZE + 3) + 2;
    localparam int DRAIN_CYCLES = SEARCH_CYCLES + 60;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        wmf_pkg::t_sample sample;
        logic             ok;
    } t_reading;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    wmf_pkg::t_sample i_sample    = '0;
    logic             i_sample_ok = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    wmf_pkg::t_sample o_mode_value;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    wmf_pkg::t_sample i_cfg_data  = '0;

    t_reading         reading_q[$];
    wmf_pkg::t_sample expected_modes[$];
    wmf_pkg::t_sample win_buf [wmf_pkg::WINDOW_SIZE];
    int unsigned      win_fill   = 0;
    wmf_pkg::t_sample cutoff_now = wmf_pkg::CUTOFF_RESET;
    logic             in_taken   = 1'b0;
    int               snd_idle_pct = 0;
    int               rcv_idle_pct = 0;
    int               err_cnt    = 0;
    int               cycle_cnt  = 0;

    windowed_mode_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_sample_ok  (i_sample_ok),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_mode_value (o_mode_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // most frequent stored reading above cutoff, lowest on ties, zero if none
    function automatic wmf_pkg::t_sample window_mode();
        int unsigned      best_n = 0;
        int unsigned      n;
        wmf_pkg::t_sample best_v = '0;
        for (int i = 0; i < wmf_pkg::WINDOW_SIZE; i++) begin
            if (win_buf[i] > cutoff_now) begin
                n = 0;
                for (int j = 0; j < wmf_pkg::WINDOW_SIZE; j++) begin
                    if (win_buf[j] == win_buf[i]) n++;
                end
                if (n > best_n || (n == best_n && win_buf[i] < best_v)) begin
                    best_n = n;
                    best_v = win_buf[i];
                end
            end
        end
        return best_v;
    endfunction

    // a full window is flushed first, even when the new read failed
    function automatic void step_window(wmf_pkg::t_sample sample, logic ok);
        if (win_fill >= wmf_pkg::WINDOW_SIZE) begin
            expected_modes.push_back(window_mode());
            win_fill = 0;
        end
        if (ok) begin
            win_buf[win_fill] = sample;
            win_fill++;
        end
    endfunction

    function automatic void log_error(string msg);
        err_cnt++;
        if (err_cnt <= REPORT_MAX) $display("mismatch: %s", msg);
    endfunction

    function automatic int clamp16(int v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    // input beats drive at the falling edge
    always @(negedge i_clk) begin : drive
        t_reading rd;
        i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        if (!i_in_valid || in_taken) begin
            if (reading_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                rd = reading_q.pop_front();
                i_in_valid  <= 1'b1;
                i_sample    <= rd.sample;
                i_sample_ok <= rd.ok;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : observe
        wmf_pkg::t_sample exp_v;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_modes.size() == 0) begin
                log_error($sformatf("unexpected mode_value %0d", o_mode_value));
            end else begin
                exp_v = expected_modes.pop_front();
                if (o_mode_value !== exp_v)
                    log_error($sformatf("mode_value expected %0d got %0d",
                                        exp_v, o_mode_value));
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) step_window(i_sample, i_sample_ok);
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_reading(int unsigned sample, logic ok);
        t_reading rd;
        rd.sample = wmf_pkg::t_sample'(sample);
        rd.ok     = ok;
        reading_q.push_back(rd);
    endtask

    // mostly readings from a small pool per window so counts repeat and tie
    task automatic queue_random(int count);
        int       pool [4];
        int       base;
        int       pick;
        t_reading rd;
        for (int k = 0; k < count; k++) begin
            if (k % wmf_pkg::WINDOW_SIZE == 0) begin
                if ($urandom_range(0, 1))
                    base = int'(cutoff_now) + int'($urandom_range(0, 8)) - 4;
                else
                    base = int'($urandom_range(0, 65535));
                foreach (pool[j]) pool[j] = clamp16(base + int'($urandom_range(0, 3)));
            end
            pick = int'($urandom_range(0, 99));
            if (pick < 70)
                rd.sample = wmf_pkg::t_sample'(pool[$urandom_range(0, 3)]);
            else if (pick < 80)
                rd.sample = wmf_pkg::t_sample'($urandom_range(0, 65535));
            else if (pick < 85)
                rd.sample = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else
                rd.sample = wmf_pkg::t_sample'(
                    clamp16(int'(cutoff_now) + int'($urandom_range(0, 2)) - 1));
            rd.ok = ($urandom_range(0, 99) < 88);
            reading_q.push_back(rd);
        end
    endtask

    // wait for every beat to go in and every mode to come out
    task automatic settle();
        while (reading_q.size() != 0 || i_in_valid || expected_modes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cutoff(wmf_pkg::t_sample val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cutoff_now = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 24;
        rcv_idle_pct = 62;
        // directed window at the reset cutoff: extremes, junk at and below
        // cutoff, failed reads, a frequency tie won by the lower value
        add_reading(65535, 1'b1);
        add_reading(0, 1'b1);
        add_reading(10000, 1'b1);
        add_reading(10000, 1'b1);
        add_reading(20000, 1'b1);
        add_reading(15000, 1'b1);
        add_reading(30000, 1'b0);
        add_reading(10000, 1'b1);
        add_reading(10000, 1'b1);
        add_reading(30000, 1'b0);
        add_reading(20000, 1'b1);
        add_reading(15000, 1'b1);
        add_reading(30000, 1'b0);
        add_reading(10001, 1'b1);
        add_reading(12345, 1'b1);
        add_reading(65535, 1'b1);
        add_reading(9999, 1'b1);
        add_reading(1, 1'b1);
        add_reading(10000, 1'b1);
        // full window flushes on a failed read
        add_reading(40000, 1'b0);
        add_reading(10000, 1'b1);
        add_reading(10001, 1'b1);
        settle();

        write_cutoff(16'h0000);
        queue_random(320);
        settle();

        // nothing can pass this cutoff, every mode is zero
        snd_idle_pct = 62;
        rcv_idle_pct = 24;
        write_cutoff(16'hFFFF);
        queue_random(200);
        settle();

        write_cutoff(wmf_pkg::t_sample'($urandom_range(1000, 60000)));
        queue_random(450);
        settle();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_cutoff(16'h0001);
        queue_random(400);
        settle();

        write_cutoff(wmf_pkg::t_sample'($urandom_range(20000, 50000)));
        queue_random(460);
        settle();

        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
